// File: rtl/core/rm2q_pkg.sv
// rm2q_pkg: shared constants, branch codes and stage payload types
`timescale 1ns / 1ps
`default_nettype none
package rm2q_pkg;
	localparam int FRAC_BITS = 14;
	localparam int ONE = 1 << FRAC_BITS;
	localparam int ELEM_W = 16;
	// radicand t * 2^(FRAC_BITS-2), t below 2^17, padded to an even width
	localparam int T_W = 17;
	localparam int RAD_W = 30;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W = ROOT_W + 5;
	localparam int D_W = 17;
	localparam int NUM_W = 32;
	localparam int QUO_W = 15;
	localparam int LANES = 3;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} br_t;

	typedef struct packed {
		logic [RAD_W-1:0]           rad;
		logic [REM_W-1:0]           rem;
		logic [ROOT_W-1:0]          root;
		logic [LANES-1:0][D_W-1:0]  d;
		br_t                        br;
	} sqrt_t;

	typedef struct packed {
		logic [LANES-1:0][NUM_W-1:0] r;
		logic [LANES-1:0][QUO_W-1:0] quo;
		logic [LANES-1:0]            ovf;
		logic [LANES-1:0]            neg;
		logic [ROOT_W-1:0]           q;
		br_t                         br;
	} div_t;

	typedef struct packed {
		logic [ELEM_W-1:0] x;
		logic [ELEM_W-1:0] y;
		logic [ELEM_W-1:0] z;
		logic [ELEM_W-1:0] w;
		br_t               br;
	} quat_t;
endpackage
`default_nettype wire

// File: rtl/core/rm2q_ifs.sv
// rm2q_mat_if and rm2q_quat_if: valid/ready channels for matrix and quaternion items
`timescale 1ns / 1ps
`default_nettype none
interface rm2q_mat_if;
	logic        valid;
	logic        ready;
	logic [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

interface rm2q_quat_if;
	logic        valid;
	logic        ready;
	logic [15:0] quat_x, quat_y, quat_z, quat_w;
	logic [1:0]  branch_taken;
	modport source (output valid, quat_x, quat_y, quat_z, quat_w, branch_taken,
		input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, branch_taken,
		output ready);
endinterface
`default_nettype wire

// File: rtl/core/rm2q_front.sv
// rm2q_front: trace test, branch pick, radicand and off-diagonal terms
`timescale 1ns / 1ps
`default_nettype none
module rm2q_front import rm2q_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [ELEM_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic                   out_valid,
	output sqrt_t                  out_s1
);
	logic signed [18:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
	logic signed [18:0] trace, t;
	logic signed [18:0] one_x;
	br_t br;
	logic [LANES-1:0][D_W-1:0] d;
	logic [T_W-1:0] t_clamp;
	sqrt_t nxt;

	always_comb begin
		a00 = 19'($signed(m00)); a01 = 19'($signed(m01)); a02 = 19'($signed(m02));
		a10 = 19'($signed(m10)); a11 = 19'($signed(m11)); a12 = 19'($signed(m12));
		a20 = 19'($signed(m20)); a21 = 19'($signed(m21)); a22 = 19'($signed(m22));
		one_x = 19'(ONE);
		trace = a00 + a11 + a22;
		if (trace > 0) br = BR_TRACE;
		else if (a00 > a11 && a00 > a22) br = BR_X;
		else if (a11 > a22) br = BR_Y;
		else br = BR_Z;
		unique case (br)
			BR_TRACE: begin
				t = one_x + trace;
				d[0] = D_W'(a21 - a12); d[1] = D_W'(a02 - a20); d[2] = D_W'(a10 - a01);
			end
			BR_X: begin
				t = one_x + a00 - a11 - a22;
				d[0] = D_W'(a21 - a12); d[1] = D_W'(a01 + a10); d[2] = D_W'(a02 + a20);
			end
			BR_Y: begin
				t = one_x + a11 - a00 - a22;
				d[0] = D_W'(a02 - a20); d[1] = D_W'(a01 + a10); d[2] = D_W'(a12 + a21);
			end
			default: begin
				t = one_x + a22 - a00 - a11;
				d[0] = D_W'(a10 - a01); d[1] = D_W'(a02 + a20); d[2] = D_W'(a12 + a21);
			end
		endcase
		// a matrix that is not a rotation can give a negative radicand
		t_clamp = t[18] ? '0 : t[T_W-1:0];
		nxt.rad  = {{(RAD_W-T_W-FRAC_BITS+2){1'b0}}, t_clamp, {(FRAC_BITS-2){1'b0}}};
		nxt.rem  = '0;
		nxt.root = '0;
		nxt.d    = d;
		nxt.br   = br;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) out_s1 <= nxt;
	end
endmodule
`default_nettype wire

// File: rtl/core/rm2q_root.sv
// rm2q_root: pipelined restoring square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module rm2q_root import rm2q_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_valid,
	input  wire sqrt_t in_data,
	output logic       out_valid,
	output sqrt_t      out_data
);
	logic  vld_s [ROOT_W];
	sqrt_t stg_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic  v_in;
		sqrt_t p, n;
		logic [REM_W-1:0] acc, trial;
		assign v_in = (k == 0) ? in_valid : vld_s[(k == 0) ? 0 : k-1];
		assign p    = (k == 0) ? in_data  : stg_s[(k == 0) ? 0 : k-1];
		always_comb begin
			n = p;
			acc   = {p.rem[REM_W-3:0], p.rad[RAD_W-1 -: 2]};
			trial = {{(REM_W-ROOT_W-2){1'b0}}, p.root, 2'b01};
			n.rad = {p.rad[RAD_W-3:0], 2'b00};
			if (acc >= trial) begin
				n.rem  = acc - trial;
				n.root = {p.root[ROOT_W-2:0], 1'b1};
			end else begin
				n.rem  = acc;
				n.root = {p.root[ROOT_W-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= v_in;
		end
		always_ff @(posedge clk) begin
			if (en) stg_s[k] <= n;
		end
	end

	assign out_valid = vld_s[ROOT_W-1];
	assign out_data  = stg_s[ROOT_W-1];
endmodule
`default_nettype wire

// File: rtl/core/rm2q_divide.sv
// rm2q_divide: three-lane pipelined restoring divider by 4*q with rounding offset
`timescale 1ns / 1ps
`default_nettype none
module rm2q_divide import rm2q_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_valid,
	input  wire sqrt_t in_data,
	output logic       out_valid,
	output div_t       out_data
);
	logic vld_s1;
	div_t prep_s1;
	div_t nprep;
	logic vld_s [QUO_W];
	div_t stg_s [QUO_W];

	// numerator |d|*ONE + den/2, overflow once the quotient reaches 2^QUO_W
	always_comb begin
		logic signed [D_W-1:0] ds;
		logic [D_W-1:0] mag;
		logic [NUM_W-1:0] num, lim;
		nprep.q  = in_data.root;
		nprep.br = in_data.br;
		lim = NUM_W'({in_data.root, 2'b00}) << QUO_W;
		for (int l = 0; l < LANES; l++) begin
			ds  = $signed(in_data.d[l]);
			mag = ds[D_W-1] ? D_W'(-ds) : D_W'(ds);
			num = (NUM_W'(mag) << FRAC_BITS) + NUM_W'({in_data.root, 1'b0});
			nprep.neg[l] = ds[D_W-1];
			nprep.ovf[l] = num >= lim;
			nprep.r[l]   = num;
			nprep.quo[l] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) prep_s1 <= nprep;
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic v_in;
		div_t p, n;
		assign v_in = (k == 0) ? vld_s1  : vld_s[(k == 0) ? 0 : k-1];
		assign p    = (k == 0) ? prep_s1 : stg_s[(k == 0) ? 0 : k-1];
		always_comb begin
			logic [NUM_W-1:0] sub;
			n = p;
			sub = NUM_W'({p.q, 2'b00}) << (QUO_W-1-k);
			for (int l = 0; l < LANES; l++) begin
				if (p.r[l] >= sub) begin
					n.r[l]   = p.r[l] - sub;
					n.quo[l] = {p.quo[l][QUO_W-2:0], 1'b1};
				end else begin
					n.quo[l] = {p.quo[l][QUO_W-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= v_in;
		end
		always_ff @(posedge clk) begin
			if (en) stg_s[k] <= n;
		end
	end

	assign out_valid = vld_s[QUO_W-1];
	assign out_data  = stg_s[QUO_W-1];
endmodule
`default_nettype wire

// File: rtl/core/rm2q_back.sv
// rm2q_back: sign, saturation and component placement into the output register
`timescale 1ns / 1ps
`default_nettype none
module rm2q_back import rm2q_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire div_t in_data,
	output logic      out_valid,
	output quat_t     out_q
);
	logic [ELEM_W-1:0] lane [LANES];
	logic [ELEM_W-1:0] rootc;
	quat_t nxt;

	always_comb begin
		logic [ELEM_W-1:0] mag;
		for (int l = 0; l < LANES; l++) begin
			if (in_data.ovf[l] || in_data.quo[l] > QUO_W'(ONE)) mag = ELEM_W'(ONE);
			else mag = ELEM_W'(in_data.quo[l]);
			// zero root leaves the divided components at zero
			if (in_data.q == '0) lane[l] = '0;
			else lane[l] = in_data.neg[l] ? ELEM_W'(-mag) : mag;
		end
		rootc = (in_data.q > ROOT_W'(ONE)) ? ELEM_W'(ONE) : ELEM_W'(in_data.q);
		nxt.br = in_data.br;
		unique case (in_data.br)
			BR_TRACE: begin nxt.w = rootc;   nxt.x = lane[0]; nxt.y = lane[1]; nxt.z = lane[2]; end
			BR_X:     begin nxt.w = lane[0]; nxt.x = rootc;   nxt.y = lane[1]; nxt.z = lane[2]; end
			BR_Y:     begin nxt.w = lane[0]; nxt.x = lane[1]; nxt.y = rootc;   nxt.z = lane[2]; end
			default:  begin nxt.w = lane[0]; nxt.x = lane[1]; nxt.y = lane[2]; nxt.z = rootc;   end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) out_q <= nxt;
	end
endmodule
`default_nettype wire

// File: rtl/core/rotation_matrix_to_quaternion_unit.sv
// rotation_matrix_to_quaternion_unit: pipelined Shepperd matrix to quaternion converter
// Accepts one 3x3 matrix item per clock and delivers its quaternion through the registers
// (one front stage, fifteen square-root stages, one divider setup stage, fifteen
// divider stages and the output register); throughput is one item per cycle, and the
// whole pipeline holds in place while the output item is not taken.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_unit import rm2q_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	rm2q_mat_if.sink    mat,
	rm2q_quat_if.source quat
);
	logic  en;
	logic  f_valid, r_valid, d_valid, o_valid;
	sqrt_t f_data, r_data;
	div_t  d_data;
	quat_t o_q;

	assign en = !o_valid || quat.ready;
	assign mat.ready = en;

	rm2q_front u_front (
		.clk, .arst_n, .en,
		.in_valid(mat.valid),
		.m00(mat.m00), .m01(mat.m01), .m02(mat.m02),
		.m10(mat.m10), .m11(mat.m11), .m12(mat.m12),
		.m20(mat.m20), .m21(mat.m21), .m22(mat.m22),
		.out_valid(f_valid), .out_s1(f_data)
	);
	rm2q_root u_root (
		.clk, .arst_n, .en,
		.in_valid(f_valid), .in_data(f_data),
		.out_valid(r_valid), .out_data(r_data)
	);
	rm2q_divide u_divide (
		.clk, .arst_n, .en,
		.in_valid(r_valid), .in_data(r_data),
		.out_valid(d_valid), .out_data(d_data)
	);
	rm2q_back u_back (
		.clk, .arst_n, .en,
		.in_valid(d_valid), .in_data(d_data),
		.out_valid(o_valid), .out_q(o_q)
	);

	assign quat.valid        = o_valid;
	assign quat.quat_x       = o_q.x;
	assign quat.quat_y       = o_q.y;
	assign quat.quat_z       = o_q.z;
	assign quat.quat_w       = o_q.w;
	assign quat.branch_taken = o_q.br;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && !quat.ready |=> quat.valid && $stable(o_q))
		else $error("output item changed while stalled");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid |-> $signed(quat.quat_x) <= ONE && $signed(quat.quat_x) >= -ONE
			&& $signed(quat.quat_w) <= ONE && $signed(quat.quat_w) >= -ONE)
		else $error("component outside unit range");
	a_trace_w: assert property (@(posedge clk) disable iff (!arst_n)
		quat.valid && quat.branch_taken == BR_TRACE |-> !quat.quat_w[ELEM_W-1])
		else $error("trace branch gave negative w");
endmodule
`default_nettype wire
